// ===== rtl/vbc_pkg.sv =====
// Shared types and constants of the voxel boundary classifier.
package vbc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGES_AS_CONTACTS = 2'd2;

    localparam logic [1:0] CLASS_EMPTY  = 2'd0;
    localparam logic [1:0] CLASS_CORNER = 2'd1;
    localparam logic [1:0] CLASS_EDGE   = 2'd2;
    localparam logic [1:0] CLASS_INSIDE = 2'd3;

    localparam int OUT_QUEUE_DEPTH = 8;

    typedef struct packed {
        logic occupied;
        logic flush;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [1:0]  cell_class;
        logic        is_contact;
        logic        last;
        logic [16:0] occupied_total;
        logic [32:0] moment_sum;
    } out_item_t;

endpackage

// ===== rtl/vbc_in_if.sv =====
// Request channel carrying occupancy cells into the classifier.
interface vbc_in_if;
    import vbc_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/vbc_out_if.sv =====
// Request channel carrying classified cells out of the classifier.
interface vbc_out_if;
    import vbc_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/vbc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module vbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/vbc_out_fifo.sv =====
// Result queue that drives the output channel and reports its fill level.
module vbc_out_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  vbc_pkg::out_item_t         push_data,
    output logic [$clog2(DEPTH+1)-1:0] count,
    vbc_out_if.source                  results
);
    import vbc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    out_item_t         entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              pop;

    assign results.valid = (count_reg != '0);
    assign results.data  = entry_reg[rd_ptr_reg];
    assign pop           = results.valid & results.ready;
    assign count         = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== rtl/voxel_boundary_classifier.sv =====
// Top level: raster 3x3 boundary classifier with occupancy count and second moment.
//
//  Channel   Dir  Handshake      Payload
//  cells     in   valid/ready    occupied, flush
//  results   out  valid/ready    cell_x, cell_y, cell_class, is_contact, last,
//                                occupied_total, moment_sum
//  cfg       in   cfg_wr_en      cfg_index, cfg_data (write only)
//
// One cell is taken per cycle while input ready is high. A result passes line RAM
// read, window and classify, squaring and accumulate before it leaves the queue.
// The first grid_width+1 requests of each grid give no result.
// Input ready is held off only when the eight-entry output queue, counting the
// requests still in the three pipeline stages, would overflow.
// The line RAM needs no clearing after reset: rows before the current grid are masked.
module voxel_boundary_classifier #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [vbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vbc_pkg::CFG_DATA_W-1:0]   cfg_data,
    vbc_in_if.sink                           cells,
    vbc_out_if.source                        results
);
    import vbc_pkg::*;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CYW  = $clog2(MAX_HEIGHT);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int YW   = $clog2(MAX_HEIGHT + 2);
    localparam int DXW  = WW + 2;
    localparam int DYW  = HW + 2;
    localparam int QCW  = $clog2(OUT_QUEUE_DEPTH + 1);
    localparam int W_RESET = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;
    localparam int H_RESET = (MAX_HEIGHT < 16) ? MAX_HEIGHT : 16;

    function automatic logic [WW-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
        logic [WW-1:0] r;
        if (v == '0)
        begin
            r = WW'(1);
        end
        else if (32'(v) > MAX_WIDTH)
        begin
            r = WW'(MAX_WIDTH);
        end
        else
        begin
            r = WW'(v);
        end
        return r;
    endfunction

    function automatic logic [HW-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
        logic [HW-1:0] r;
        if (v == '0)
        begin
            r = HW'(1);
        end
        else if (32'(v) > MAX_HEIGHT)
        begin
            r = HW'(MAX_HEIGHT);
        end
        else
        begin
            r = HW'(v);
        end
        return r;
    endfunction

    // Configuration
    logic [WW-1:0]  w_reg;
    logic [HW-1:0]  h_reg;
    logic           edges_as_contacts_reg;
    logic [XW-1:0]  w_last;
    logic [CYW-1:0] h_last;
    logic           restart;

    // Input position and classified cell position
    logic [XW-1:0]  ix_reg, ix_next;
    logic [YW-1:0]  iy_reg, iy_next;
    logic [XW-1:0]  cx_reg, cx_next;
    logic [CYW-1:0] cy_reg, cy_next;

    logic           accept;
    logic           in_bit;
    logic           in_emit;
    logic           in_last;

    // Stage 1: line RAM read data arrives
    logic           s1_valid_reg;
    logic           s1_bit_reg;
    logic [XW-1:0]  s1_ix_reg;
    logic           s1_iy_zero_reg;
    logic           s1_emit_reg;
    logic [XW-1:0]  s1_cx_reg;
    logic [CYW-1:0] s1_cy_reg;
    logic           s1_last_reg;
    logic           s1_fwd_reg;
    logic [1:0]     s1_fwd_data_reg;

    logic [1:0]     ram_rdata;
    logic [1:0]     ram_wdata;
    logic [1:0]     stored;
    logic           col_top;
    logic           col_mid;
    logic [2:0]     new_col;
    logic [2:0]     col_a_reg;
    logic [2:0]     col_b_reg;
    logic [2:0]     left_col;
    logic [2:0]     mid_col;
    logic [2:0]     right_col;
    logic           center;
    logic           corner;
    logic           edge_hit;
    logic [1:0]     cls;
    logic           contact;
    logic signed [DXW-1:0] dx_val;
    logic signed [DYW-1:0] dy_val;

    // Stage 2: classified, offsets known
    logic           s2_valid_reg;
    logic [XW-1:0]  s2_cx_reg;
    logic [CYW-1:0] s2_cy_reg;
    logic [1:0]     s2_class_reg;
    logic           s2_contact_reg;
    logic           s2_last_reg;
    logic           s2_occ_reg;
    logic signed [DXW-1:0] s2_dx_reg;
    logic signed [DYW-1:0] s2_dy_reg;
    logic signed [2*DXW-1:0] dx_sq;
    logic signed [2*DYW-1:0] dy_sq;

    // Stage 3: squares ready, accumulate and queue
    logic           s3_valid_reg;
    logic [XW-1:0]  s3_cx_reg;
    logic [CYW-1:0] s3_cy_reg;
    logic [1:0]     s3_class_reg;
    logic           s3_contact_reg;
    logic           s3_last_reg;
    logic           s3_occ_reg;
    logic [2*DXW-1:0] s3_dx2_reg;
    logic [2*DYW-1:0] s3_dy2_reg;

    logic [16:0]    count_acc_reg, count_acc_next;
    logic [32:0]    moment_acc_reg, moment_acc_next;
    logic [32:0]    moment_inc;
    out_item_t      push_data;

    logic [QCW-1:0] queue_count;
    logic [QCW:0]   queue_demand;

    assign w_last  = XW'(w_reg - WW'(1));
    assign h_last  = CYW'(h_reg - HW'(1));
    assign restart = cfg_wr_en &&
                     (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg                 <= WW'(W_RESET);
            h_reg                 <= HW'(H_RESET);
            edges_as_contacts_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:        w_reg <= clamp_width(cfg_data);
                REG_GRID_HEIGHT:       h_reg <= clamp_height(cfg_data);
                REG_EDGES_AS_CONTACTS: edges_as_contacts_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Input side
    assign queue_demand = (QCW+1)'(queue_count) + (QCW+1)'(s1_valid_reg)
                        + (QCW+1)'(s2_valid_reg) + (QCW+1)'(s3_valid_reg);
    assign cells.ready  = (queue_demand < (QCW+1)'(OUT_QUEUE_DEPTH));
    assign accept       = cells.valid & cells.ready;

    // Cells past the bottom row act as empty padding.
    assign in_bit  = (iy_reg < YW'(h_reg)) & ~cells.data.flush & cells.data.occupied;
    assign in_emit = (iy_reg >= YW'(2)) || ((iy_reg == YW'(1)) && (ix_reg != '0));
    assign in_last = in_emit && (cx_reg == w_last) && (cy_reg == h_last);

    always_comb
    begin
        ix_next = ix_reg;
        iy_next = iy_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (restart)
        begin
            ix_next = '0;
            iy_next = '0;
            cx_next = '0;
            cy_next = '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                ix_next = '0;
                iy_next = '0;
                cx_next = '0;
                cy_next = '0;
            end
            else
            begin
                if (ix_reg == w_last)
                begin
                    ix_next = '0;
                    iy_next = iy_reg + YW'(1);
                end
                else
                begin
                    ix_next = ix_reg + XW'(1);
                end
                if (in_emit)
                begin
                    if (cx_reg == w_last)
                    begin
                        cx_next = '0;
                        cy_next = cy_reg + CYW'(1);
                    end
                    else
                    begin
                        cx_next = cx_reg + XW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ix_reg       <= '0;
            iy_reg       <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            ix_reg       <= ix_next;
            iy_reg       <= iy_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg & s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Each entry holds the column's two rows above the incoming row.
    vbc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_ix_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ix_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bit_reg      <= in_bit;
            s1_ix_reg       <= ix_reg;
            s1_iy_zero_reg  <= (iy_reg == '0);
            s1_emit_reg     <= in_emit;
            s1_cx_reg       <= cx_reg;
            s1_cy_reg       <= cy_reg;
            s1_last_reg     <= in_last;
            // With a one-cell row the next read hits the entry written this cycle.
            s1_fwd_reg      <= s1_valid_reg && (ix_reg == s1_ix_reg);
            s1_fwd_data_reg <= ram_wdata;
        end
    end

    // Stage 1: build the new column and classify the window center.
    assign stored    = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign col_top   = ~s1_iy_zero_reg & stored[1];
    assign col_mid   = ~s1_iy_zero_reg & stored[0];
    assign new_col   = {s1_bit_reg, col_mid, col_top};
    assign ram_wdata = {col_mid, s1_bit_reg};

    assign left_col  = (s1_cx_reg == '0) ? 3'b000 : col_a_reg;
    assign mid_col   = col_b_reg;
    assign right_col = (s1_cx_reg == w_last) ? 3'b000 : new_col;
    assign center    = mid_col[1];

    assign corner = (~left_col[0]  & ~left_col[1]  & ~mid_col[0])
                  | (~right_col[0] & ~right_col[1] & ~mid_col[0])
                  | (~left_col[2]  & ~left_col[1]  & ~mid_col[2])
                  | (~right_col[2] & ~right_col[1] & ~mid_col[2]);
    assign edge_hit = ~right_col[1] | ~left_col[1] | ~mid_col[2] | ~mid_col[0];

    always_comb
    begin
        if (!center)
        begin
            cls = CLASS_EMPTY;
        end
        else if (corner)
        begin
            cls = CLASS_CORNER;
        end
        else if (edge_hit)
        begin
            cls = CLASS_EDGE;
        end
        else
        begin
            cls = CLASS_INSIDE;
        end
    end

    assign contact = center & (corner | (edge_hit & edges_as_contacts_reg));
    assign dx_val  = signed'(DXW'({s1_cx_reg, 1'b1}) - DXW'(w_reg));
    assign dy_val  = signed'(DYW'({s1_cy_reg, 1'b1}) - DYW'(h_reg));

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            col_a_reg      <= col_b_reg;
            col_b_reg      <= new_col;
            s2_cx_reg      <= s1_cx_reg;
            s2_cy_reg      <= s1_cy_reg;
            s2_class_reg   <= cls;
            s2_contact_reg <= contact;
            s2_last_reg    <= s1_last_reg;
            s2_occ_reg     <= center;
            s2_dx_reg      <= dx_val;
            s2_dy_reg      <= dy_val;
        end
    end

    // Stage 2: squares of the centered offsets.
    assign dx_sq = s2_dx_reg * s2_dx_reg;
    assign dy_sq = s2_dy_reg * s2_dy_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_cx_reg      <= s2_cx_reg;
            s3_cy_reg      <= s2_cy_reg;
            s3_class_reg   <= s2_class_reg;
            s3_contact_reg <= s2_contact_reg;
            s3_last_reg    <= s2_last_reg;
            s3_occ_reg     <= s2_occ_reg;
            s3_dx2_reg     <= unsigned'(dx_sq);
            s3_dy2_reg     <= unsigned'(dy_sq);
        end
    end

    // Stage 3: accumulate totals and queue the result.
    assign moment_inc      = s3_occ_reg ? (33'(s3_dx2_reg) + 33'(s3_dy2_reg)) : 33'd0;
    assign count_acc_next  = count_acc_reg + 17'(s3_occ_reg);
    assign moment_acc_next = moment_acc_reg + moment_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_acc_reg  <= '0;
            moment_acc_reg <= '0;
        end
        else if (restart)
        begin
            count_acc_reg  <= '0;
            moment_acc_reg <= '0;
        end
        else if (s3_valid_reg)
        begin
            if (s3_last_reg)
            begin
                count_acc_reg  <= '0;
                moment_acc_reg <= '0;
            end
            else
            begin
                count_acc_reg  <= count_acc_next;
                moment_acc_reg <= moment_acc_next;
            end
        end
    end

    always_comb
    begin
        push_data.cell_x         = 8'(s3_cx_reg);
        push_data.cell_y         = 8'(s3_cy_reg);
        push_data.cell_class     = s3_class_reg;
        push_data.is_contact     = s3_contact_reg;
        push_data.last           = s3_last_reg;
        push_data.occupied_total = s3_last_reg ? count_acc_next : 17'd0;
        push_data.moment_sum     = s3_last_reg ? moment_acc_next : 33'd0;
    end

    vbc_out_fifo #(
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data (push_data),
        .count     (queue_count),
        .results   (results)
    );
endmodule

// ===== sim/tb.sv =====
// Testbench for the voxel boundary classifier: drives occupancy grids and checks every result.
`timescale 1ns / 100ps

module tb;
    import vbc_pkg::*;

    localparam int GRID_MAX       = 256;
    localparam int RANDOM_REQS    = 400;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 100;

    typedef struct {
        logic        occupied;
        logic        flush;
        int unsigned gap;
    } cell_req_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    vbc_in_if  cells ();
    vbc_out_if results ();

    voxel_boundary_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cells),
        .results   (results)
    );

    // Requests waiting to be driven and results the classifier owes us.
    cell_req_t   cell_reqs[$];
    cell_req_t   next_req;
    out_item_t   expected_cells[$];
    out_item_t   want;

    // Shadow of the classifier: registers, line contents and accumulators.
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic        edges_reg;
    bit          cell_bits [0:GRID_MAX*GRID_MAX+GRID_MAX];
    int unsigned grid_pos;
    logic [16:0] count_acc;
    logic [33:0] moment_acc;

    int unsigned tx_max_gap  = 11;
    int unsigned rx_max_wait = 11;
    int unsigned rx_wait     = 0;
    bit          stall_request = 1'b0;
    bit          stall_taken   = 1'b0;
    int unsigned stall_left    = 0;
    int unsigned quiet_cycles  = 0;

    int unsigned error_count   = 0;
    int unsigned accepted_reqs = 0;
    int unsigned checked_cells = 0;
    int unsigned setup_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned effective_dim(input logic [8:0] value);
        if (value == 9'd0)
            return 1;
        if (int'(value) > GRID_MAX)
            return GRID_MAX;
        return int'(value);
    endfunction

    function automatic void restart_grid();
        grid_pos   = 0;
        count_acc  = '0;
        moment_acc = '0;
    endfunction

    function automatic bit grid_bit(input int nx, input int ny, input int w, input int h);
        if (nx < 0 || ny < 0 || nx >= w || ny >= h)
            return 1'b0;
        return cell_bits[17'(ny * w + nx)];
    endfunction

    // Stores one request in the shadow grid and queues the cell it completes, if any.
    task automatic predict_cell(input logic occ, input logic flush);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned c;
        int          x;
        int          y;
        longint      dx;
        longint      dy;
        logic        corner;
        logic        edge_cell;
        logic        last_cell;
        out_item_t   res;
        w     = effective_dim(width_reg);
        h     = effective_dim(height_reg);
        total = w * h;
        cell_bits[17'(grid_pos)] = (grid_pos < total) && !flush && occ;
        if (grid_pos < w + 1)
        begin
            grid_pos++;
            return;
        end
        c = grid_pos - w - 1;
        x = c % w;
        y = c / w;
        res = '0;
        res.cell_x     = x[7:0];
        res.cell_y     = y[7:0];
        res.cell_class = CLASS_EMPTY;
        if (grid_bit(x, y, w, h))
        begin
            corner = 1'b0;
            for (int sy = -1; sy <= 1; sy += 2)
                for (int sx = -1; sx <= 1; sx += 2)
                    if (!grid_bit(x + sx, y + sy, w, h) && !grid_bit(x + sx, y, w, h)
                        && !grid_bit(x, y + sy, w, h))
                        corner = 1'b1;
            edge_cell = !corner && (!grid_bit(x + 1, y, w, h) || !grid_bit(x - 1, y, w, h)
                                    || !grid_bit(x, y + 1, w, h) || !grid_bit(x, y - 1, w, h));
            res.cell_class = corner ? CLASS_CORNER : (edge_cell ? CLASS_EDGE : CLASS_INSIDE);
            res.is_contact = corner || (edge_cell && edges_reg);
            dx = longint'(2 * x + 1) - longint'(w);
            dy = longint'(2 * y + 1) - longint'(h);
            count_acc  = count_acc + 17'd1;
            moment_acc = moment_acc + 34'(dx * dx + dy * dy);
        end
        last_cell = (c == total - 1);
        res.last = last_cell;
        if (last_cell)
        begin
            res.occupied_total = count_acc;
            res.moment_sum     = moment_acc[32:0];
            restart_grid();
        end
        else
            grid_pos++;
        expected_cells.push_back(res);
    endtask

    function automatic void note_mismatch(input string field, input longint exp_val,
                                          input longint act_val);
        if (error_count < MAX_REPORTS)
            $error("%s: expected %0d, got %0d", field, exp_val, act_val);
        error_count++;
    endfunction

    // Request driver: each request waits out its own gap before valid goes high.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells.valid <= 1'b0;
            cells.data  <= '0;
        end
        else
        begin
            if (cells.valid && cells.ready)
            begin
                predict_cell(cells.data.occupied, cells.data.flush);
                accepted_reqs++;
            end
            if (!cells.valid || cells.ready)
            begin
                if (cell_reqs.size() == 0)
                    cells.valid <= 1'b0;
                else if (cell_reqs[0].gap != 0)
                begin
                    cell_reqs[0].gap--;
                    cells.valid <= 1'b0;
                end
                else
                begin
                    next_req = cell_reqs.pop_front();
                    cells.data.occupied <= next_req.occupied;
                    cells.data.flush    <= next_req.flush;
                    cells.valid         <= 1'b1;
                end
            end
        end
    end

    // Long hold-off of the result side, so that the classifier has to stall its input.
    always @(posedge clk)
    begin
        if (stall_request && !stall_taken)
        begin
            stall_left  <= STALL_CYCLES;
            stall_taken <= 1'b1;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // Result monitor with a random wait after every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $error("result for cell %0d,%0d with nothing expected",
                               results.data.cell_x, results.data.cell_y);
                    error_count++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (results.data.cell_x !== want.cell_x)
                        note_mismatch("cell_x", longint'(want.cell_x),
                                      longint'(results.data.cell_x));
                    if (results.data.cell_y !== want.cell_y)
                        note_mismatch("cell_y", longint'(want.cell_y),
                                      longint'(results.data.cell_y));
                    if (results.data.cell_class !== want.cell_class)
                        note_mismatch("cell_class", longint'(want.cell_class),
                                      longint'(results.data.cell_class));
                    if (results.data.is_contact !== want.is_contact)
                        note_mismatch("is_contact", longint'(want.is_contact),
                                      longint'(results.data.is_contact));
                    if (results.data.last !== want.last)
                        note_mismatch("last", longint'(want.last),
                                      longint'(results.data.last));
                    if (results.data.occupied_total !== want.occupied_total)
                        note_mismatch("occupied_total", longint'(want.occupied_total),
                                      longint'(results.data.occupied_total));
                    if (results.data.moment_sum !== want.moment_sum)
                        note_mismatch("moment_sum", longint'(want.moment_sum),
                                      longint'(results.data.moment_sum));
                    checked_cells++;
                end
                rx_wait = $urandom_range(rx_max_wait, 0);
            end
            if (rx_wait != 0)
            begin
                rx_wait--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= (stall_left == 0);
        end
    end

    // Watchdog: the run is stuck if no request and no result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cells.valid && cells.ready) || (results.valid && results.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("voxel_boundary_classifier verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_cell(input logic occ, input logic flush);
        cell_req_t req;
        req.occupied = occ;
        req.flush    = flush;
        req.gap      = $urandom_range(tx_max_gap, 0);
        cell_reqs.push_back(req);
    endtask

    // Queues the first n_reqs requests of a grid: cells first, then the drain requests.
    task automatic queue_grid(input int unsigned w, input int unsigned h,
                              input int unsigned density, input int unsigned n_reqs,
                              input int unsigned flush_pct);
        for (int unsigned i = 0; i < n_reqs; i++)
        begin
            if (i < w * h)
                queue_cell($urandom_range(99, 0) < density, $urandom_range(99, 0) < flush_pct);
            else
                queue_cell($urandom_range(1, 0) == 1, $urandom_range(3, 0) != 0);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_GRID_WIDTH:
            begin
                width_reg = value;
                restart_grid();
            end
            REG_GRID_HEIGHT:
            begin
                height_reg = value;
                restart_grid();
            end
            REG_EDGES_AS_CONTACTS:
                edges_reg = value[0];
            default:
                ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every request is in and every result is out, then lets the pipeline empty.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (cell_reqs.size() != 0 || cells.valid || expected_cells.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic setup_grid(input logic [8:0] w, input logic [8:0] h, input logic edges);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_EDGES_AS_CONTACTS, {8'd0, edges});
        setup_count++;
    endtask

    initial
    begin
        int unsigned random_reqs;
        int unsigned ew;
        int unsigned eh;
        int unsigned n_grids;
        int unsigned n_reqs;
        int unsigned density;
        logic [8:0]  w_val;
        logic [8:0]  h_val;
        logic [8:0]  big_dims [4];
        logic [11:0] l_shape;

        cells.valid   = 1'b0;
        cells.data    = '0;
        results.ready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_GRID_WIDTH;
        cfg_data      = '0;
        rst_n         = 1'b0;
        width_reg     = 9'd16;
        height_reg    = 9'd16;
        edges_reg     = 1'b0;
        restart_grid();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A zero width and height act as a single cell, which must come out as a corner.
        // The first drain request is a plain occupied cell lying past the grid.
        setup_grid(9'd0, 9'd0, 1'b0);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b1, 1'b0);
        queue_cell(1'b0, 1'b1);
        wait_idle();

        // Four by three with a notch in the top row and a flushed last cell.
        setup_grid(9'd4, 9'd3, 1'b1);
        l_shape = 12'b1111_1111_0111;
        for (int i = 0; i < 12; i++)
            queue_cell(l_shape[4'(i)], i == 11);
        for (int i = 0; i < 5; i++)
            queue_cell(~i[1], ~i[0]);
        wait_idle();

        // A partial grid, abandoned by the next geometry write.
        write_reg(REG_GRID_WIDTH, 9'd5);
        for (int i = 0; i < 6; i++)
            queue_cell(i[0], 1'b0);
        wait_idle();

        // Back-pressure: results are held off while requests keep coming.
        tx_max_gap  = 0;
        rx_max_wait = 11;
        setup_grid(9'd12, 9'd10, 1'b1);
        stall_request = 1'b1;
        queue_grid(12, 10, 50, 12 * 10 + 13, 5);
        random_reqs = 12 * 10 + 13;
        wait_idle();

        big_dims[0] = 9'd256;
        big_dims[1] = 9'd257;
        big_dims[2] = 9'd511;
        while (random_reqs < RANDOM_REQS)
        begin
            big_dims[3] = 9'($urandom_range(300, 13));
            case ($urandom_range(7, 0))
                0:
                begin
                    w_val = big_dims[2'($urandom_range(3, 0))];
                    h_val = 9'($urandom_range(2, 0));
                end
                1:
                begin
                    w_val = 9'($urandom_range(2, 0));
                    h_val = big_dims[2'($urandom_range(3, 0))];
                end
                default:
                begin
                    w_val = 9'($urandom_range(12, 0));
                    h_val = 9'($urandom_range(10, 0));
                end
            endcase
            case ($urandom_range(3, 0))
                0:
                begin
                    tx_max_gap  = 11;
                    rx_max_wait = 11;
                end
                1:
                begin
                    tx_max_gap  = 0;
                    rx_max_wait = 0;
                end
                2:
                begin
                    tx_max_gap  = 11;
                    rx_max_wait = 0;
                end
                default:
                begin
                    tx_max_gap  = 0;
                    rx_max_wait = 11;
                end
            endcase
            setup_grid(w_val, h_val, 1'($urandom_range(1, 0)));
            ew      = effective_dim(w_val);
            eh      = effective_dim(h_val);
            density = $urandom_range(2, 0) * 40 + 10;
            n_grids = (ew * eh > 200) ? 1 : $urandom_range(2, 1);
            for (int unsigned g = 0; g < n_grids; g++)
            begin
                n_reqs = ew * eh + ew + 1;
                // Now and then the last grid is cut short; the next setup restarts the stream.
                if (g == n_grids - 1 && $urandom_range(9, 0) == 0)
                    n_reqs = $urandom_range(n_reqs - 1, 0);
                // Large grids are cut at the request budget of the run.
                if (random_reqs >= RANDOM_REQS)
                    n_reqs = 0;
                else if (n_reqs > RANDOM_REQS - random_reqs)
                    n_reqs = RANDOM_REQS - random_reqs;
                queue_grid(ew, eh, density, n_reqs, 5);
                random_reqs += n_reqs;
            end
            wait_idle();
        end

        $display("Checked %0d classified cells from %0d requests over %0d grid setups,",
                 checked_cells, accepted_reqs, setup_count);
        $display("including clamped geometry and a %0d-cycle result stall.", STALL_CYCLES);
        if (error_count == 0)
            $display("voxel_boundary_classifier verification clean");
        else
            $display("voxel_boundary_classifier verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vbc_pkg.sv
rtl/vbc_in_if.sv
rtl/vbc_out_if.sv
rtl/vbc_ram.sv
rtl/vbc_out_fifo.sv
rtl/voxel_boundary_classifier.sv
sim/tb.sv
